// ----- hw/rtl/stq_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// stq_pkg
// Shared constants, codes, controller/datapath interface types and the
// operator functions of the sparse table range query block.
// ---------------------------------------------------------------------------
package stq_pkg;

   localparam int MAX_N      = 1024;
   localparam int LEVELS     = 11;
   localparam int VALUE_BITS = 32;

   localparam int IDX_BITS  = $clog2(MAX_N);
   localparam int CNT_BITS  = IDX_BITS + 1;
   localparam int LVL_BITS  = $clog2(LEVELS);
   localparam int ADDR_BITS = LVL_BITS + IDX_BITS;
   localparam int MEM_DEPTH = LEVELS * MAX_N;

   localparam int CMD_BITS = 3;
   localparam int ST_BITS  = 2;
   localparam int OP_BITS  = 3;
   localparam int LR_BITS  = 11;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_BUILD  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_GET    = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd4;

   // status codes
   localparam logic [ST_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [ST_BITS-1:0] ST_BAD_RANGE = 2'd1;
   localparam logic [ST_BITS-1:0] ST_NOT_BUILT = 2'd2;
   localparam logic [ST_BITS-1:0] ST_FULL      = 2'd3;

   // operator modes
   localparam logic [OP_BITS-1:0] OP_UMIN = 3'd0;
   localparam logic [OP_BITS-1:0] OP_UMAX = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SMIN = 3'd2;
   localparam logic [OP_BITS-1:0] OP_SMAX = 3'd3;
   localparam logic [OP_BITS-1:0] OP_AND  = 3'd4;
   localparam logic [OP_BITS-1:0] OP_OR   = 3'd5;

   localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      RD_BLD_A = 3'd0,
      RD_BLD_B = 3'd1,
      RD_QRY_A = 3'd2,
      RD_QRY_B = 3'd3,
      RD_GET   = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO  = 2'd0,
      RES_IDENT = 2'd1,
      RES_COMB  = 2'd2,
      RES_READ  = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        append;
      logic        clear;
      logic        set_built;
      logic        build_init;
      logic        build_next_j;
      logic        build_next_lvl;
      logic        build_wr;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        latch_a;
      logic        finish;
      res_sel_type res_sel;
   } stq_cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic [ST_BITS-1:0]  code;
      logic                q_empty;
      logic                lvl_more;
      logic                j_last;
   } stq_stat_type;

   function automatic logic [VALUE_BITS-1:0] op_combine(
      input logic [OP_BITS-1:0]    mode,
      input logic [VALUE_BITS-1:0] a,
      input logic [VALUE_BITS-1:0] b
   );
      logic [VALUE_BITS-1:0] sa;
      logic [VALUE_BITS-1:0] sb;
      logic [VALUE_BITS-1:0] res;
      sa = a ^ SIGN_BIT;
      sb = b ^ SIGN_BIT;
      unique case (mode)
         OP_UMAX: res = (a > b) ? a : b;
         OP_SMIN: res = (sa < sb) ? a : b;
         OP_SMAX: res = (sa > sb) ? a : b;
         OP_AND:  res = a & b;
         OP_OR:   res = a | b;
         default: res = (a < b) ? a : b;
      endcase
      return res;
   endfunction

   function automatic logic [VALUE_BITS-1:0] op_identity(input logic [OP_BITS-1:0] mode);
      logic [VALUE_BITS-1:0] res;
      unique case (mode)
         OP_UMAX: res = '0;
         OP_SMIN: res = ~SIGN_BIT;
         OP_SMAX: res = SIGN_BIT;
         OP_AND:  res = '1;
         OP_OR:   res = '0;
         default: res = '1;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stq_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// stq_ctrl
// Sequencer: decodes each accepted item and steps the datapath through
// appends, level builds, queries and element reads.
// ---------------------------------------------------------------------------
module stq_ctrl
   import stq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   input  stq_stat_type stat,
   output stq_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_BLD_CHK  = 9'b000000100,
      S_BLD_RDA  = 9'b000001000,
      S_BLD_RDB  = 9'b000010000,
      S_BLD_WR   = 9'b000100000,
      S_QRY_RDB  = 9'b001000000,
      S_QRY_FIN  = 9'b010000000,
      S_GET_FIN  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.cmd)
               CMD_APPEND: begin
                  cmd.append  = (stat.code == ST_OK);
                  cmd.finish  = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  state_in    = S_IDLE;
               end
               CMD_BUILD: begin
                  cmd.build_init = 1'b1;
                  state_in       = S_BLD_CHK;
               end
               CMD_QUERY: begin
                  if (stat.code != ST_OK) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_ZERO;
                     state_in    = S_IDLE;
                  end else if (stat.q_empty) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_IDENT;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_QRY_A;
                     state_in   = S_QRY_RDB;
                  end
               end
               CMD_GET: begin
                  if (stat.code != ST_OK) begin
                     cmd.finish  = 1'b1;
                     cmd.res_sel = RES_ZERO;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_GET;
                     state_in   = S_GET_FIN;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.finish  = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  state_in    = S_IDLE;
               end
               default: begin
                  cmd.finish  = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_BLD_CHK: begin
            if (stat.lvl_more) begin
               state_in = S_BLD_RDA;
            end else begin
               cmd.set_built = 1'b1;
               cmd.finish    = 1'b1;
               cmd.res_sel   = RES_ZERO;
               state_in      = S_IDLE;
            end
         end
         S_BLD_RDA: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BLD_A;
            state_in   = S_BLD_RDB;
         end
         S_BLD_RDB: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_BLD_B;
            cmd.latch_a = 1'b1;
            state_in    = S_BLD_WR;
         end
         S_BLD_WR: begin
            cmd.build_wr = 1'b1;
            if (stat.j_last) begin
               cmd.build_next_lvl = 1'b1;
               state_in           = S_BLD_CHK;
            end else begin
               cmd.build_next_j = 1'b1;
               state_in         = S_BLD_RDA;
            end
         end
         S_QRY_RDB: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_QRY_B;
            cmd.latch_a = 1'b1;
            state_in    = S_QRY_FIN;
         end
         S_QRY_FIN: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = RES_COMB;
            state_in    = S_IDLE;
         end
         S_GET_FIN: begin
            cmd.finish  = 1'b1;
            cmd.res_sel = RES_READ;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/stq_dpath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// stq_dpath
// Level memory, element count, built flag, operator register, build walk
// counters, query address math and the result registers.
// ---------------------------------------------------------------------------
module stq_dpath
   import stq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CMD_BITS-1:0]   req_cmd,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [LR_BITS-1:0]    req_range_left,
   input  wire logic [LR_BITS-1:0]    req_range_right,
   input  wire logic                  csr_write_en,
   input  wire logic [OP_BITS-1:0]    csr_write_data,
   input  stq_cmd_type                cmd,
   output stq_stat_type               stat,
   output logic                       rsp_valid,
   output logic [VALUE_BITS-1:0]      rsp_result_value,
   output logic [ST_BITS-1:0]         rsp_status,
   output logic [CNT_BITS-1:0]        rsp_length
);

   logic [VALUE_BITS-1:0] mem [MEM_DEPTH];

   logic [CMD_BITS-1:0]   cmd_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [LR_BITS-1:0]    left_ff;
   logic [LR_BITS-1:0]    right_ff;

   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  built_ff;
   logic                  built_in;
   logic [OP_BITS-1:0]    op_mode_ff;

   logic [LVL_BITS-1:0]   lvl_ff;
   logic [IDX_BITS-1:0]   j_ff;

   logic [VALUE_BITS-1:0] rdata_ff;
   logic [VALUE_BITS-1:0] opa_ff;

   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [ST_BITS-1:0]    rsp_status_ff;
   logic [CNT_BITS-1:0]   rsp_length_ff;

   logic [CNT_BITS:0]     half;
   logic [CNT_BITS:0]     two_half;
   logic [CNT_BITS:0]     j_end;
   logic [LR_BITS-1:0]    span;
   logic [LVL_BITS-1:0]   qlvl;
   logic [LR_BITS-1:0]    right_start;
   logic [ST_BITS-1:0]    code;
   logic                  full;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] comb_value;
   logic [VALUE_BITS-1:0] res_value;

   // build walk: level lvl_ff pairs entries half apart
   assign half     = (CNT_BITS+1)'(1) << lvl_ff;
   assign two_half = half << 1;
   assign j_end    = (CNT_BITS+1)'(count_ff) - two_half;

   // query level is floor(log2(r - l)), capped at the top level
   assign span = right_ff - left_ff;
   always_comb begin
      logic [LVL_BITS:0] u;
      u = '0;
      for (int i = 0; i < LR_BITS; i++) begin
         if (span[i]) begin
            u = (LVL_BITS+1)'(i);
         end
      end
      if (u > (LVL_BITS+1)'(LEVELS - 1)) begin
         u = (LVL_BITS+1)'(LEVELS - 1);
      end
      qlvl = u[LVL_BITS-1:0];
   end
   assign right_start = right_ff - (LR_BITS'(1) << qlvl);

   assign full = (count_ff == CNT_BITS'(MAX_N));

   always_comb begin
      code = ST_OK;
      unique case (cmd_ff)
         CMD_APPEND: begin
            if (full) begin
               code = ST_FULL;
            end
         end
         CMD_QUERY: begin
            if (!built_ff) begin
               code = ST_NOT_BUILT;
            end else if ((left_ff > right_ff) ||
                         (right_ff > LR_BITS'(count_ff))) begin
               code = ST_BAD_RANGE;
            end
         end
         CMD_GET: begin
            if (left_ff >= LR_BITS'(count_ff)) begin
               code = ST_BAD_RANGE;
            end
         end
         default: begin
            code = ST_OK;
         end
      endcase
   end

   assign stat.cmd      = cmd_ff;
   assign stat.code     = code;
   assign stat.q_empty  = (left_ff == right_ff);
   assign stat.lvl_more = ((32'(lvl_ff) + 1) < LEVELS) &&
                          (two_half <= (CNT_BITS+1)'(count_ff));
   assign stat.j_last   = ((CNT_BITS+1)'(j_ff) == j_end);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_BLD_A: rd_addr = {lvl_ff, j_ff};
         RD_BLD_B: rd_addr = {lvl_ff, j_ff + half[IDX_BITS-1:0]};
         RD_QRY_A: rd_addr = {qlvl, left_ff[IDX_BITS-1:0]};
         RD_QRY_B: rd_addr = {qlvl, right_start[IDX_BITS-1:0]};
         RD_GET:   rd_addr = {LVL_BITS'(0), left_ff[IDX_BITS-1:0]};
         default:  rd_addr = {LVL_BITS'(0), left_ff[IDX_BITS-1:0]};
      endcase
   end

   assign comb_value = op_combine(op_mode_ff, opa_ff, rdata_ff);

   always_comb begin
      if (cmd.build_wr) begin
         wr_addr = {lvl_ff + LVL_BITS'(1), j_ff};
         wr_data = comb_value;
      end else begin
         wr_addr = {LVL_BITS'(0), count_ff[IDX_BITS-1:0]};
         wr_data = val_ff;
      end
   end
   assign wr_en = cmd.build_wr || cmd.append;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      built_in = built_ff;
      if (csr_write_en || cmd.clear || cmd.append) begin
         built_in = 1'b0;
      end else if (cmd.set_built) begin
         built_in = 1'b1;
      end
   end

   always_comb begin
      unique case (cmd.res_sel)
         RES_ZERO:  res_value = '0;
         RES_IDENT: res_value = op_identity(op_mode_ff);
         RES_COMB:  res_value = comb_value;
         RES_READ:  res_value = rdata_ff;
         default:   res_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         built_ff     <= 1'b0;
         op_mode_ff   <= OP_UMIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         built_ff     <= built_in;
         rsp_valid_ff <= cmd.finish;
         if (csr_write_en) begin
            op_mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         val_ff   <= req_value;
         left_ff  <= req_range_left;
         right_ff <= req_range_right;
      end
      if (cmd.build_init) begin
         lvl_ff <= '0;
         j_ff   <= '0;
      end else if (cmd.build_next_lvl) begin
         lvl_ff <= lvl_ff + LVL_BITS'(1);
         j_ff   <= '0;
      end else if (cmd.build_next_j) begin
         j_ff <= j_ff + IDX_BITS'(1);
      end
      if (cmd.latch_a) begin
         opa_ff <= rdata_ff;
      end
      if (cmd.finish) begin
         rsp_value_ff  <= res_value;
         rsp_status_ff <= code;
         rsp_length_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_length       = rsp_length_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/sparse_table_range_query.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sparse_table_range_query
// Sparse table over up to MAX_N words with a selectable idempotent operator.
//
// Usage:
//  - an item transfers when start is high and busy is low; req_cmd selects
//    append, build, range query on [left, right), get element or clear
//  - every item yields exactly one result: rsp_valid is high for one cycle
//    with rsp_result_value, rsp_status and rsp_length; there is no back
//    pressure on the result side
//  - csr_write_data sets the operator on csr_write_en (write only while
//    idle); it drops the built state, so a build is needed again
//  - append, clear and error or empty results finish in the dispatch
//    state, get in S_GET_FIN, range query in S_QRY_FIN after S_QRY_RDB
//  - build: per level a check, then S_BLD_RDA, S_BLD_RDB and S_BLD_WR per
//    entry; each new entry takes two reads and one write of the level
//    memory, which has a single read port, and that sets the pace
//  - busy drops together with the result cycle, so a new item may
//    transfer while a result is shown
//  - reset empties the table, drops the built state, selects unsigned min
// ---------------------------------------------------------------------------
module sparse_table_range_query
   import stq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [CMD_BITS-1:0]   req_cmd,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [LR_BITS-1:0]    req_range_left,
   input  wire logic [LR_BITS-1:0]    req_range_right,
   input  wire logic                  csr_write_en,
   input  wire logic [OP_BITS-1:0]    csr_write_data,
   output logic                       rsp_valid,
   output logic [VALUE_BITS-1:0]      rsp_result_value,
   output logic [ST_BITS-1:0]         rsp_status,
   output logic [CNT_BITS-1:0]        rsp_length
);

   stq_cmd_type  cmd;
   stq_stat_type stat;

   stq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   stq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_range_left   (req_range_left),
      .req_range_right  (req_range_right),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_length       (rsp_length)
   );

   // a result is posted only as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted item always makes the block busy in the cycle after the transfer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item transfer did not raise busy");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length <= CNT_BITS'(MAX_N)))
      else $error("length beyond table size");

   // table full is only reported with a full table
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_length == CNT_BITS'(MAX_N)))
      else $error("table full reported with room left");

endmodule
`default_nettype wire

// ----- tb/stq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stq_checker
// Watches the command, result and csr ports of the sparse table range query
// block. Keeps its own copy of the table, the level entries, the element
// count, the built state and the operator, works out the answer for every
// command transfer, and compares each result transfer field by field with
// the oldest answer still due.
// ---------------------------------------------------------------------------
module stq_checker
   import stq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_BITS-1:0]   req_cmd,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [LR_BITS-1:0]    req_range_left,
   input  logic [LR_BITS-1:0]    req_range_right,
   input  logic                  csr_write_en,
   input  logic [OP_BITS-1:0]    csr_write_data,
   input  logic                  rsp_valid,
   input  logic [VALUE_BITS-1:0] rsp_result_value,
   input  logic [ST_BITS-1:0]    rsp_status,
   input  logic [CNT_BITS-1:0]   rsp_length,
   output int                    fail_count,
   output int                    answers_due
);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [ST_BITS-1:0]    status;
      logic [CNT_BITS-1:0]   length;
   } answer_type;

   logic [VALUE_BITS-1:0] level_words [LEVELS][MAX_N];
   int                    elem_count;
   logic                  table_built;
   logic [OP_BITS-1:0]    op_mode;
   answer_type            pending_answers [$];

   function automatic logic [VALUE_BITS-1:0] merge_pair(
      input logic [VALUE_BITS-1:0] a,
      input logic [VALUE_BITS-1:0] b
   );
      case (op_mode)
         OP_UMAX: return (a > b) ? a : b;
         OP_SMIN: return ($signed(a) < $signed(b)) ? a : b;
         OP_SMAX: return ($signed(a) > $signed(b)) ? a : b;
         OP_AND:  return a & b;
         OP_OR:   return a | b;
         default: return (a < b) ? a : b;
      endcase
   endfunction

   // value that leaves any operand unchanged under the current operator
   function automatic logic [VALUE_BITS-1:0] neutral_word();
      case (op_mode)
         OP_UMAX: return '0;
         OP_SMIN: return {1'b0, {(VALUE_BITS-1){1'b1}}};
         OP_SMAX: return {1'b1, {(VALUE_BITS-1){1'b0}}};
         OP_OR:   return '0;
         default: return '1;
      endcase
   endfunction

   // applies one command to the table copy and returns the answer it gives
   function automatic answer_type run_command(
      input logic [CMD_BITS-1:0]   cmd,
      input logic [VALUE_BITS-1:0] value,
      input int                    left,
      input int                    right
   );
      answer_type ans;
      int         half;
      int         span;
      int         lvl;
      ans.value  = '0;
      ans.status = ST_OK;
      case (cmd)
         CMD_APPEND: begin
            if (elem_count >= MAX_N) begin
               ans.status = ST_FULL;
            end else begin
               level_words[0][elem_count] = value;
               elem_count++;
               table_built = 1'b0;
            end
         end
         CMD_BUILD: begin
            for (int i = 0; i + 1 < LEVELS; i++) begin
               half = 1 << i;
               if (2 * half > elem_count) break;
               for (int j = 0; j <= elem_count - 2 * half; j++)
                  level_words[i+1][j] = merge_pair(level_words[i][j], level_words[i][j+half]);
            end
            table_built = 1'b1;
         end
         CMD_QUERY: begin
            if (!table_built) begin
               ans.status = ST_NOT_BUILT;
            end else if (left > right || right > elem_count) begin
               ans.status = ST_BAD_RANGE;
            end else if (left == right) begin
               ans.value = neutral_word();
            end else begin
               span = right - left;
               lvl  = 0;
               while (span > 1) begin
                  span = span >> 1;
                  lvl++;
               end
               if (lvl >= LEVELS) lvl = LEVELS - 1;
               // two overlapping blocks of 2^lvl cover the range
               ans.value = merge_pair(level_words[lvl][left % MAX_N],
                                      level_words[lvl][(right - (1 << lvl)) % MAX_N]);
            end
         end
         CMD_GET: begin
            if (left < elem_count) ans.value = level_words[0][left];
            else ans.status = ST_BAD_RANGE;
         end
         CMD_CLEAR: begin
            elem_count  = 0;
            table_built = 1'b0;
         end
         default: ;
      endcase
      ans.length = elem_count[CNT_BITS-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         elem_count  = 0;
         table_built = 1'b0;
         op_mode     = OP_UMIN;
         pending_answers.delete();
      end else begin
         // a result can leave while the next command transfers
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $error("result with no answer due: value %h status %0d length %0d",
                      rsp_result_value, rsp_status, rsp_length);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value mismatch: expected %h, got %h",
                         want.value, rsp_result_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_length !== want.length) begin
                  $error("length mismatch: expected %0d, got %0d", want.length, rsp_length);
                  fail_count++;
               end
            end
         end
         if (csr_write_en) begin
            op_mode     = csr_write_data;
            table_built = 1'b0;
         end
         if (start && !busy)
            pending_answers.push_back(run_command(req_cmd, req_value,
                                                  int'(req_range_left),
                                                  int'(req_range_right)));
      end
      answers_due = pending_answers.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the sparse table range query block with a short directed sequence
// and then with random phases: each phase picks an operator, loads a table,
// builds it and fires mostly well-formed range queries and gets, mixed with
// stray commands and out-of-range bounds. One phase fills the table to
// capacity. Commands go out in bursts with random gaps; answers are checked
// by stq_checker.
// ---------------------------------------------------------------------------
module testbench;
   import stq_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic [OP_BITS-1:0]  OP_SPARE_LAST    = 3'd7;
   localparam logic [LR_BITS-1:0]  BOUND_ALL_ONES   = '1;
   localparam int                  TARGET_ITEMS     = 1700;
   localparam int                  FULL_PHASE       = 3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_BITS-1:0]   req_cmd;
   logic [VALUE_BITS-1:0] req_value;
   logic [LR_BITS-1:0]    req_range_left;
   logic [LR_BITS-1:0]    req_range_right;
   logic                  csr_write_en;
   logic [OP_BITS-1:0]    csr_write_data;
   logic                  rsp_valid;
   logic [VALUE_BITS-1:0] rsp_result_value;
   logic [ST_BITS-1:0]    rsp_status;
   logic [CNT_BITS-1:0]   rsp_length;
   int                    fail_count;
   int                    answers_due;

   int                    items_sent = 0;
   int                    burst_left = 0;
   bit                    no_gaps    = 1'b0;

   sparse_table_range_query u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_range_left   (req_range_left),
      .req_range_right  (req_range_right),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_length       (rsp_length)
   );

   stq_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_range_left   (req_range_left),
      .req_range_right  (req_range_right),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_length       (rsp_length),
      .fail_count       (fail_count),
      .answers_due      (answers_due)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #10_000_000;
      $display("FAIL sparse_table_range_query");
      $finish;
   end

   // skewed toward extremes and near-ties so min and max see sign flips
   function automatic logic [VALUE_BITS-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return $urandom_range(0, 15);
         5: return 32'h8000_0000 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_BITS-1:0] CMD_CMD_SPARE_PICK();
      return CMD_BITS'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
   endfunction

   // one command transfer, preceded by a gap when a burst runs out
   task automatic issue(
      input logic [CMD_BITS-1:0]   c,
      input logic [VALUE_BITS-1:0] v,
      input logic [LR_BITS-1:0]    l,
      input logic [LR_BITS-1:0]    r
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_cmd         <= c;
      req_value       <= v;
      req_range_left  <= l;
      req_range_right <= r;
      start           <= 1'b1;
      items_sent++;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and wait until every answer has come back
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (answers_due != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_mode(input logic [OP_BITS-1:0] m);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      int                 phase;
      int                 table_len;
      int                 n_load;
      int                 n_ops;
      int                 pick;
      logic [LR_BITS-1:0] lo;
      logic [LR_BITS-1:0] hi;
      logic [OP_BITS-1:0] mode;
      bit                 full_phase;

      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_APPEND;
      req_value       = '0;
      req_range_left  = '0;
      req_range_right = '0;
      csr_write_en    = 1'b0;
      csr_write_data  = OP_UMIN;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, errors, spare commands, clear
      issue(CMD_QUERY, '0, 11'd0, 11'd0);
      issue(CMD_GET, '0, 11'd0, 11'd0);
      issue(CMD_BUILD, '0, 11'd0, 11'd0);
      issue(CMD_QUERY, '0, 11'd0, 11'd0);
      issue(CMD_QUERY, '0, 11'd0, 11'd1);
      issue(CMD_APPEND, 32'h0000_0000, 11'd0, 11'd0);
      issue(CMD_APPEND, 32'hffff_ffff, 11'd0, 11'd0);
      issue(CMD_APPEND, 32'h8000_0000, 11'd0, 11'd0);
      issue(CMD_APPEND, 32'h7fff_ffff, 11'd0, 11'd0);
      issue(CMD_APPEND, 32'h1234_5678, 11'd0, 11'd0);
      issue(CMD_QUERY, '0, 11'd0, 11'd5);
      issue(CMD_BUILD, '0, 11'd0, 11'd0);
      issue(CMD_QUERY, '0, 11'd0, 11'd5);
      issue(CMD_QUERY, '0, 11'd1, 11'd3);
      issue(CMD_QUERY, '0, 11'd4, 11'd5);
      issue(CMD_QUERY, '0, 11'd3, 11'd2);
      issue(CMD_QUERY, '0, 11'd2, 11'd6);
      issue(CMD_QUERY, '0, BOUND_ALL_ONES, BOUND_ALL_ONES);
      issue(CMD_GET, '0, 11'd4, 11'd0);
      issue(CMD_GET, '0, 11'd5, 11'd0);
      issue(CMD_GET, '0, BOUND_ALL_ONES, BOUND_ALL_ONES);
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
         issue(CMD_BITS'(c), '1, '1, '1);
      issue(CMD_CLEAR, '0, 11'd0, 11'd0);
      issue(CMD_GET, '0, 11'd0, 11'd0);

      // random phases, one operator each; every operator code including spares
      phase     = 0;
      table_len = 0;
      while (items_sent < TARGET_ITEMS || phase <= OP_SPARE_LAST) begin
         mode       = (phase <= OP_SPARE_LAST) ? OP_BITS'(phase) : OP_BITS'($urandom_range(0, 7));
         full_phase = (phase == FULL_PHASE);
         write_mode(mode);
         no_gaps = ($urandom_range(0, 3) == 0);
         // operator change drops the built state
         if (table_len > 0)
            issue(CMD_QUERY, '0, 11'd0, LR_BITS'(table_len));
         issue(CMD_CLEAR, rand_word(), '0, '0);
         table_len = 0;
         if (full_phase) n_load = MAX_N + 2;
         else if ($urandom_range(0, 9) == 0) n_load = $urandom_range(64, 300);
         else n_load = $urandom_range(1, 40);
         repeat (n_load) begin
            issue(CMD_APPEND, rand_word(), LR_BITS'($urandom), LR_BITS'($urandom));
            if (table_len < MAX_N) table_len++;
         end
         issue(CMD_BUILD, rand_word(), '0, '0);
         n_ops = full_phase ? 60 : $urandom_range(20, 60);
         repeat (n_ops) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               if ($urandom_range(0, 9) == 0) begin
                  lo = '0;
                  hi = LR_BITS'(table_len);
               end else begin
                  lo = LR_BITS'($urandom_range(0, table_len));
                  hi = LR_BITS'($urandom_range(lo, table_len));
               end
               issue(CMD_QUERY, rand_word(), lo, hi);
            end else if (pick < 78) begin
               issue(CMD_GET, rand_word(), LR_BITS'($urandom_range(0, table_len)), '0);
            end else if (pick < 83) begin
               issue(CMD_QUERY, rand_word(), LR_BITS'($urandom), LR_BITS'($urandom));
            end else if (pick < 86) begin
               issue(CMD_CMD_SPARE_PICK(), $urandom, LR_BITS'($urandom), LR_BITS'($urandom));
            end else if (pick < 90) begin
               issue(CMD_APPEND, rand_word(), '0, '0);
               if (table_len < MAX_N) table_len++;
               issue(CMD_BUILD, '0, '0, '0);
            end else if (pick < 94) begin
               issue(CMD_APPEND, rand_word(), '0, '0);
               if (table_len < MAX_N) table_len++;
               issue(CMD_QUERY, '0, '0, LR_BITS'(table_len));
               issue(CMD_BUILD, '0, '0, '0);
            end else if (pick < 97 || table_len > 300) begin
               issue(CMD_GET, '0, LR_BITS'($urandom), '0);
            end else begin
               issue(CMD_BUILD, rand_word(), '0, '0);
            end
         end
         phase++;
      end

      settle();
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS sparse_table_range_query");
      end else begin
         $display("FAIL sparse_table_range_query");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/stq_pkg.sv
hw/rtl/stq_ctrl.sv
hw/rtl/stq_dpath.sv
hw/rtl/sparse_table_range_query.sv
tb/stq_checker.sv
tb/testbench.sv
